// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the inode slot parser RTL.
// No dependencies; included by xfs_inode_slot_parser, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Same, on the block's own aclk / aresetn.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLKD(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/xisp_pkg.sv =====
// Shared constants for the inode slot parser: on-disk layout offsets,
// magic values, field widths and stream packing. No dependencies.
package xisp_pkg;

    // Build-time defaults for the top-level parameters
    localparam int DEF_MAX_SLOT_BYTES = 2048;
    localparam int DEF_MAX_EXTENTS    = 128;

    // Inode size register
    localparam int CFG_W            = 12;
    localparam int MIN_SLOT_BYTES   = 256;
    localparam int RESET_SLOT_BYTES = 512;

    // Inode core layout
    localparam logic [15:0] INODE_MAGIC    = 16'h494E;
    localparam logic [15:0] MODE_TYPE_MASK = 16'hF000;
    localparam logic [7:0]  VERSION_V3     = 8'd3;
    localparam logic [7:0]  FMT_EXTENTS    = 8'd2;
    localparam int          FORK_OFF_V2    = 96;
    localparam int          FORK_OFF_V3    = 176;
    localparam int          EXT_REC_BYTES  = 16;

    // Record kinds carried on tuser
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_EXTENT = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 328;
    localparam int OUT_PAD_W   = 6;

endpackage

// ===== rtl/core/xisp_size_reg.sv =====
// Inode size register: checks each write and keeps the size and its log2.
// Depends on xisp_pkg.
module xisp_size_reg import xisp_pkg::*; #(
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    parameter int SIZE_W         = $clog2(MAX_SLOT_BYTES) + 1,
    parameter int SHIFT_W        = $clog2(SIZE_W)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    output logic [SIZE_W-1:0]  slot_bytes,
    output logic [SHIFT_W-1:0] size_shift
);

    logic [SIZE_W-1:0]  size_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               wr_ok;
    logic [SHIFT_W-1:0] shift_calc;

    // Only powers of two in the supported range are taken
    always_comb begin
        wr_ok = (cfg_wr_data >= CFG_W'(MIN_SLOT_BYTES))
             && (cfg_wr_data <= CFG_W'(MAX_SLOT_BYTES))
             && ((cfg_wr_data & (cfg_wr_data - CFG_W'(1))) == '0);
        shift_calc = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (cfg_wr_data[i]) begin
                shift_calc = SHIFT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SIZE_W'(RESET_SLOT_BYTES);
            shift_reg <= SHIFT_W'($clog2(RESET_SLOT_BYTES));
        end else if (cfg_wr_en && wr_ok) begin
            size_reg  <= cfg_wr_data[SIZE_W-1:0];
            shift_reg <= shift_calc;
        end
    end

    assign slot_bytes = size_reg;
    assign size_shift = shift_reg;

endmodule

// ===== rtl/core/xfs_inode_slot_parser.sv =====
// Inode slot parser top level: byte-wise field capture, record build and
// the result register. Depends on xisp_pkg, xisp_size_reg, assert_macros.svh.
//
// Usage:
//   s_* channel takes one raw slot byte per request, tdata = {offset, byte}.
//   The slot offset is sampled on the first byte of each slot; a byte counter
//   walks the slot and wraps at the configured inode size.
//   m_* channel delivers header records (tuser = 0) on the byte just before
//   the data fork, and one extent record (tuser = 1) on the last byte of each
//   16-byte extent that fits in the slot; tlast marks the slot's last record.
//   Slots with a bad magic or a zero file type give no records.
//   A result is on m_* in the cycle after the byte that caused it.
//   Throughput: one byte per cycle unless stalled; field decode and record
//   build sit between the state registers and a single result register.
//   Stall: while a result waits on a low m_tready, s_tready is low; it rises
//   in the cycle the result is taken, so a ready sink sees no bubbles.
//   cfg_wr_en / cfg_wr_data write the inode size (256..MAX_SLOT_BYTES, power
//   of two); other values are dropped. Write only while the stream is idle.
//   Reset: counter and captured fields clear, inode size returns to 512,
//   no result pending.
`include "assert_macros.svh"

module xfs_inode_slot_parser import xisp_pkg::*; #(
    parameter int MAX_SLOT_BYTES = DEF_MAX_SLOT_BYTES,
    parameter int MAX_EXTENTS    = DEF_MAX_EXTENTS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config: inode size
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] data_byte, [71:8] slot_disk_offset
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [63:0] inode_number, [79:64] file_mode, [111:80] owner_uid,
    // [143:112] owner_gid, [207:144] size_bytes, [215:208] fork_format,
    // [247:216] extent_total, [299:248] ext_start_block,
    // [320:300] ext_block_count, [321] ext_unwritten, [327:322] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] record_kind
    output logic                   m_tuser,
    // last_of_slot
    output logic                   m_tlast
);

    localparam int POS_W   = $clog2(MAX_SLOT_BYTES);
    localparam int SIZE_W  = POS_W + 1;
    localparam int SHIFT_W = $clog2(SIZE_W);
    localparam int ORD_W   = POS_W - 4;
    localparam int EXT_W   = $clog2(MAX_EXTENTS + 1);
    localparam int LIM_W   = (EXT_W > ORD_W + 1) ? EXT_W : ORD_W + 1;

    // Size register
    logic [SIZE_W-1:0]  slot_bytes;
    logic [SHIFT_W-1:0] size_shift;

    xisp_size_reg #(
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES),
        .SIZE_W         (SIZE_W),
        .SHIFT_W        (SHIFT_W)
    ) u_size_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .slot_bytes  (slot_bytes),
        .size_shift  (size_shift)
    );

    // Slot state
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [63:0]      base_reg,    base_next;
    logic [15:0]      magic_reg,   magic_next;
    logic [15:0]      mode_reg,    mode_next;
    logic [7:0]       version_reg, version_next;
    logic [7:0]       format_reg,  format_next;
    logic [31:0]      uid_reg,     uid_next;
    logic [31:0]      gid_reg,     gid_next;
    logic [63:0]      fsize_reg,   fsize_next;
    logic [31:0]      total_reg,   total_next;
    logic [63:0]      embed_reg,   embed_next;
    logic [127:0]     shift_reg,   shift_next;

    // Result register
    logic                   m_tvalid_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                   in_fire;
    logic [7:0]             byte_in;
    logic [63:0]            off_in;
    logic [POS_W-1:0]       fork_start;
    logic [POS_W-1:0]       rel;
    logic [ORD_W-1:0]       ord;
    logic [SIZE_W-1:0]      room;
    logic [SIZE_W-1:0]      pos_inc;
    logic [LIM_W-1:0]       limit;
    logic                   accepted;
    logic                   in_fork;
    logic                   hdr_hit;
    logic                   ext_hit;
    logic                   res_last;
    logic [63:0]            ino_num;
    logic [51:0]            ext_start;
    logic [20:0]            ext_count;
    logic                   ext_unw;
    logic [OUT_TDATA_W-1:0] res_data;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign byte_in  = s_tdata[7:0];
    assign off_in   = s_tdata[71:8];

    // Field capture at fixed slot offsets, big-endian
    always_comb begin
        base_next    = base_reg;
        magic_next   = magic_reg;
        mode_next    = mode_reg;
        version_next = version_reg;
        format_next  = format_reg;
        uid_next     = uid_reg;
        gid_next     = gid_reg;
        fsize_next   = fsize_reg;
        total_next   = total_reg;
        embed_next   = embed_reg;

        if (pos_reg == '0) begin
            base_next = off_in;
        end

        if (pos_reg < POS_W'(2)) begin
            magic_next = {magic_reg[7:0], byte_in};
        end else if (pos_reg < POS_W'(4)) begin
            mode_next = {mode_reg[7:0], byte_in};
        end else if (pos_reg == POS_W'(4)) begin
            version_next = byte_in;
        end else if (pos_reg == POS_W'(5)) begin
            format_next = byte_in;
        end else if (pos_reg >= POS_W'(8) && pos_reg < POS_W'(12)) begin
            uid_next = {uid_reg[23:0], byte_in};
        end else if (pos_reg >= POS_W'(12) && pos_reg < POS_W'(16)) begin
            gid_next = {gid_reg[23:0], byte_in};
        end else if (pos_reg >= POS_W'(56) && pos_reg < POS_W'(64)) begin
            fsize_next = {fsize_reg[55:0], byte_in};
        end else if (pos_reg >= POS_W'(76) && pos_reg < POS_W'(80)) begin
            total_next = {total_reg[23:0], byte_in};
        end else if (pos_reg >= POS_W'(152) && pos_reg < POS_W'(160)) begin
            embed_next = {embed_reg[55:0], byte_in};
        end
    end

    // Data fork position, extent shift and limit, record decisions, byte counter
    always_comb begin
        fork_start = (version_next >= VERSION_V3) ? POS_W'(FORK_OFF_V3) : POS_W'(FORK_OFF_V2);
        in_fork  = (pos_reg >= fork_start);
        rel      = pos_reg - fork_start;
        ord      = rel[POS_W-1:4];
        accepted = (magic_next == INODE_MAGIC) && ((mode_next & MODE_TYPE_MASK) != '0);

        shift_next = shift_reg;
        if (in_fork) begin
            shift_next = {shift_reg[119:0], byte_in};
        end

        room  = (slot_bytes - {1'b0, fork_start}) >> $clog2(EXT_REC_BYTES);
        limit = '0;
        if (format_next == FMT_EXTENTS && total_next != '0 && total_next[31:16] == '0) begin
            if (total_next > 32'(MAX_EXTENTS)) begin
                limit = LIM_W'(MAX_EXTENTS);
            end else begin
                limit = total_next[LIM_W-1:0];
            end
            if (slot_bytes > {1'b0, fork_start}) begin
                if (limit > LIM_W'(room)) begin
                    limit = LIM_W'(room);
                end
            end else begin
                limit = '0;
            end
        end

        hdr_hit = (pos_reg == fork_start - POS_W'(1)) && accepted;
        ext_hit = in_fork && (rel[3:0] == 4'hF) && (LIM_W'(ord) < limit) && accepted;

        if (hdr_hit) begin
            res_last = (limit == '0);
        end else begin
            res_last = ((LIM_W'(ord) + LIM_W'(1)) == limit);
        end

        pos_inc = {1'b0, pos_reg} + SIZE_W'(1);
        if (pos_inc >= slot_bytes) begin
            pos_next = '0;
        end else begin
            pos_next = pos_inc[POS_W-1:0];
        end
    end

    // Record payload
    always_comb begin
        if (version_next >= VERSION_V3 && embed_next != '0) begin
            ino_num = embed_next;
        end else begin
            ino_num = base_next >> size_shift;
        end
        if (hdr_hit) begin
            ext_start = '0;
            ext_count = '0;
            ext_unw   = 1'b0;
        end else begin
            ext_start = {shift_next[72:64], shift_next[63:21]};
            ext_count = shift_next[20:0];
            ext_unw   = shift_next[127];
        end
        res_data = {{OUT_PAD_W{1'b0}}, ext_unw, ext_count, ext_start, total_next,
                    format_next, fsize_next, gid_next, uid_next, mode_next, ino_num};
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            base_reg    <= '0;
            magic_reg   <= '0;
            mode_reg    <= '0;
            version_reg <= '0;
            format_reg  <= '0;
            uid_reg     <= '0;
            gid_reg     <= '0;
            fsize_reg   <= '0;
            total_reg   <= '0;
            embed_reg   <= '0;
            shift_reg   <= '0;
        end else if (in_fire) begin
            pos_reg     <= pos_next;
            base_reg    <= base_next;
            magic_reg   <= magic_next;
            mode_reg    <= mode_next;
            version_reg <= version_next;
            format_reg  <= format_next;
            uid_reg     <= uid_next;
            gid_reg     <= gid_next;
            fsize_reg   <= fsize_next;
            total_reg   <= total_next;
            embed_reg   <= embed_next;
            shift_reg   <= shift_next;
        end
    end

    // Result register: load on a record, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire && (hdr_hit || ext_hit)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (hdr_hit || ext_hit)) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= hdr_hit ? KIND_HEADER : KIND_EXTENT;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    `ASSERT_STD(a_base_sampled, (in_fire && pos_reg == '0) |=> (base_reg == $past(off_in)), "slot offset not sampled on first byte")
    `ASSERT_STD(a_hdr_at_fork, (in_fire && hdr_hit) |=> (pos_reg == POS_W'(FORK_OFF_V2) || pos_reg == POS_W'(FORK_OFF_V3)), "header record off the fork boundary")
    `ASSERT_STD(a_ext_aligned, (in_fire && ext_hit) |=> (pos_reg[3:0] == 4'h0), "extent record not on a 16-byte boundary")

endmodule

// ===== test/tb_xfs_inode_slot_parser.sv =====
`timescale 1ns / 1ps
// Self-checking bench for xfs_inode_slot_parser: streams raw inode slots in
// bursts, predicts header and extent records in a scoreboard class and checks
// every record taken from the result stream. Depends on xisp_pkg and the RTL.

module tb_xfs_inode_slot_parser;
    import xisp_pkg::*;

    localparam int MAX_EXT = DEF_MAX_EXTENTS;

    // One expected or observed parser record
    typedef struct {
        logic        kind;
        logic [63:0] inode_number;
        logic [15:0] file_mode;
        logic [31:0] owner_uid;
        logic [31:0] owner_gid;
        logic [63:0] size_bytes;
        logic [7:0]  fork_format;
        logic [31:0] extent_total;
        logic [51:0] start_block;
        logic [20:0] block_count;
        logic        unwritten;
        logic        last;
    } inode_rec_t;

    // Tracks the slot walk and inode core fields, predicts records, checks them
    class inode_record_scoreboard;
        int unsigned slot_size;
        int unsigned pos;
        logic [63:0] base_off;
        logic [15:0] magic;
        logic [15:0] mode;
        logic [7:0]  version;
        logic [7:0]  format;
        logic [31:0] uid;
        logic [31:0] gid;
        logic [31:0] ext_total;
        logic [63:0] size_bytes;
        logic [63:0] embedded;
        logic [63:0] ext_hi;
        logic [63:0] ext_lo;
        inode_rec_t  expected_q[$];
        int          mismatches;
        int          predicted;

        function new();
            slot_size  = RESET_SLOT_BYTES;
            pos        = 0;
            base_off   = '0;
            magic      = '0;
            mode       = '0;
            version    = '0;
            format     = '0;
            uid        = '0;
            gid        = '0;
            ext_total  = '0;
            size_bytes = '0;
            embedded   = '0;
            ext_hi     = '0;
            ext_lo     = '0;
            mismatches = 0;
            predicted  = 0;
        endfunction

        // Only powers of two in the legal range take effect
        function void write_size(logic [CFG_W-1:0] v);
            int unsigned n;
            n = v;
            if (n >= MIN_SLOT_BYTES && n <= DEF_MAX_SLOT_BYTES && (n & (n - 1)) == 0)
                slot_size = n;
        endfunction

        function bit accepted();
            return magic == INODE_MAGIC && (mode & MODE_TYPE_MASK) != 0;
        endfunction

        function logic [63:0] inode_num();
            if (version >= VERSION_V3 && embedded != 0)
                return embedded;
            return base_off >> $clog2(slot_size);
        endfunction

        function inode_rec_t core_record(logic kind, logic last);
            inode_rec_t r;
            r.kind         = kind;
            r.inode_number = inode_num();
            r.file_mode    = mode;
            r.owner_uid    = uid;
            r.owner_gid    = gid;
            r.size_bytes   = size_bytes;
            r.fork_format  = format;
            r.extent_total = ext_total;
            r.start_block  = '0;
            r.block_count  = '0;
            r.unwritten    = 1'b0;
            r.last         = last;
            return r;
        endfunction

        // One accepted byte request: update captures, queue any record it causes
        function void note_byte(logic [7:0] b, logic [63:0] off);
            int unsigned fork_start;
            int unsigned lim;
            int unsigned rel;
            inode_rec_t  r;
            if (pos == 0)
                base_off = off;

            if (pos < 2)
                magic = {magic[7:0], b};
            else if (pos < 4)
                mode = {mode[7:0], b};
            else if (pos == 4)
                version = b;
            else if (pos == 5)
                format = b;
            else if (pos >= 8 && pos < 12)
                uid = {uid[23:0], b};
            else if (pos >= 12 && pos < 16)
                gid = {gid[23:0], b};
            else if (pos >= 56 && pos < 64)
                size_bytes = {size_bytes[55:0], b};
            else if (pos >= 76 && pos < 80)
                ext_total = {ext_total[23:0], b};
            else if (pos >= 152 && pos < 160)
                embedded = {embedded[55:0], b};

            // number of extent records this slot may yield
            fork_start = (version >= VERSION_V3) ? FORK_OFF_V3 : FORK_OFF_V2;
            lim = 0;
            if (format == FMT_EXTENTS && ext_total != 0 && ext_total < 65536) begin
                lim = (ext_total > MAX_EXT) ? MAX_EXT : ext_total;
                if (slot_size > fork_start) begin
                    if (lim > (slot_size - fork_start) / EXT_REC_BYTES)
                        lim = (slot_size - fork_start) / EXT_REC_BYTES;
                end else begin
                    lim = 0;
                end
            end

            if (pos + 1 == fork_start && accepted()) begin
                expected_q.insert(expected_q.size(), core_record(KIND_HEADER, lim == 0));
                predicted++;
            end else if (pos >= fork_start) begin
                rel = pos - fork_start;
                {ext_hi, ext_lo} = {ext_hi[55:0], ext_lo, b};
                if ((rel & 15) == 15 && (rel >> 4) < lim && accepted()) begin
                    r = core_record(KIND_EXTENT, (rel >> 4) + 1 == lim);
                    r.start_block = {ext_hi[8:0], ext_lo[63:21]};
                    r.block_count = ext_lo[20:0];
                    r.unwritten   = ext_hi[63];
                    expected_q.insert(expected_q.size(), r);
                    predicted++;
                end
            end

            pos = (pos + 1 >= slot_size) ? 0 : ((pos + 1) & 32'h7FF);
        endfunction

        function void cmp(string fname, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] %s mismatch: expected %h, got %h",
                             $time, fname, exp_v, got_v);
            end
        endfunction

        // One accepted result request, compared with the oldest prediction
        function void check_record(logic [OUT_TDATA_W-1:0] d, logic kind, logic last);
            inode_rec_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] record with nothing predicted: kind %0d inode %h",
                             $time, kind, d[63:0]);
                return;
            end
            e = expected_q.pop_front();
            cmp("record_kind", 64'(e.kind), 64'(kind));
            cmp("inode_number", e.inode_number, d[63:0]);
            cmp("file_mode", 64'(e.file_mode), 64'(d[79:64]));
            cmp("owner_uid", 64'(e.owner_uid), 64'(d[111:80]));
            cmp("owner_gid", 64'(e.owner_gid), 64'(d[143:112]));
            cmp("size_bytes", e.size_bytes, d[207:144]);
            cmp("fork_format", 64'(e.fork_format), 64'(d[215:208]));
            cmp("extent_total", 64'(e.extent_total), 64'(d[247:216]));
            cmp("ext_start_block", 64'(e.start_block), 64'(d[299:248]));
            cmp("ext_block_count", 64'(e.block_count), 64'(d[320:300]));
            cmp("ext_unwritten", 64'(e.unwritten), 64'(d[321]));
            cmp("last_of_slot", 64'(e.last), 64'(last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    inode_record_scoreboard sb = new();

    logic [7:0]       slot_img [DEF_MAX_SLOT_BYTES];
    logic [CFG_W-1:0] bad_sizes [7] = '{12'd0, 12'hFFF, 12'd300, 12'd128, 12'hC00,
                                       12'd1, 12'd768};

    // sender and receiver pacing
    bit          src_bursty;
    int          burst_left;
    int          sink_style;
    int          hold_left;
    int unsigned stall_tick;

    xfs_inode_slot_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: long hold-off when asked, otherwise the current stall pattern
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall_tick++;
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                case (sink_style)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 99) < 60);
                    default: m_tready = ((stall_tick % 7) >= 3);
                endcase
            end
        end
    end

    // Every record taken from the result stream
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_record(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        #10_000_000;
        $display("tb_xfs_inode_slot_parser: done, errors");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one byte request, hold it until taken; called and returns at negedge
    task automatic send_byte(input logic [7:0] b, input logic [63:0] off);
        if (src_bursty) begin
            if (burst_left == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = $urandom_range(1, 48);
            end
            burst_left--;
        end
        s_tvalid = 1'b1;
        s_tdata  = {off, b};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_byte(b, off);
        @(negedge aclk);
    endtask

    // Stop offering and wait for every predicted record, then settle
    task automatic drain(input int settle);
        int guard;
        guard = 0;
        s_tvalid = 1'b0;
        while (sb.pending() != 0 && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_slot_size(input logic [CFG_W-1:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.write_size(v);
    endtask

    task automatic put_be(input int at, input int nbytes, input logic [63:0] v);
        for (int i = 0; i < nbytes; i++)
            slot_img[at + i] = v[8 * (nbytes - 1 - i) +: 8];
    endtask

    // Random slot image with the given core fields in big-endian order
    task automatic build_slot(input logic [15:0] magic, input logic [15:0] mode,
                              input logic [7:0] ver, input logic [7:0] fmt,
                              input logic [31:0] ext_cnt, input logic [63:0] ino);
        for (int i = 0; i < DEF_MAX_SLOT_BYTES; i++)
            slot_img[i] = 8'($urandom);
        put_be(0, 2, magic);
        put_be(2, 2, mode);
        slot_img[4] = ver;
        slot_img[5] = fmt;
        put_be(76, 4, ext_cnt);
        if (ver >= VERSION_V3)
            put_be(152, 8, ino);
    endtask

    task automatic send_slot(input logic [63:0] off, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(slot_img[i], (i == 0) ? off : rand64());
    endtask

    // Finish a slot cut short by a size change, keeping its image
    task automatic finish_slot();
        while (sb.pos != 0)
            send_byte(slot_img[sb.pos], rand64());
    endtask

    // Mostly well-formed slots; some bad magic, zero type, odd counts
    task automatic random_slot();
        int unsigned pick;
        int unsigned room;
        logic [15:0] magic;
        logic [15:0] mode;
        logic [7:0]  ver;
        logic [7:0]  fmt;
        logic [31:0] cnt;
        logic [63:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            magic = INODE_MAGIC;
        else if (pick < 94)
            magic = INODE_MAGIC ^ (16'h1 << $urandom_range(0, 15));
        else
            magic = 16'($urandom);
        mode = {4'($urandom_range(1, 15)), 12'($urandom)};
        if ($urandom_range(0, 9) == 0)
            mode[15:12] = 4'h0;
        case ($urandom_range(0, 4))
            0:       ver = 8'd1;
            1:       ver = 8'd2;
            2, 3:    ver = VERSION_V3;
            default: ver = 8'($urandom);
        endcase
        fmt = ($urandom_range(0, 9) < 8) ? FMT_EXTENTS : 8'($urandom);
        room = (sb.slot_size - ((ver >= VERSION_V3) ? FORK_OFF_V3 : FORK_OFF_V2))
               / EXT_REC_BYTES;
        case ($urandom_range(0, 9))
            0:       cnt = 32'd0;
            1:       cnt = $urandom_range(65535, 65536);
            2:       cnt = $urandom;
            3:       cnt = room + $urandom_range(1, 200);
            default: cnt = $urandom_range(1, room);
        endcase
        if ($urandom_range(0, 3) == 0)
            off = rand64();
        else
            off = 64'($urandom_range(0, 1 << 20)) * sb.slot_size;
        build_slot(magic, mode, ver, fmt, cnt, $urandom_range(0, 1) ? rand64() : 64'h0);
        send_slot(off, sb.slot_size);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        sink_style  = 0;
        src_bursty  = 1'b0;
        hold_left   = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // reset size under a long receiver hold-off, so the block fills and
        // stalls its input; then shrink mid-slot and let the counter wrap
        hold_left  = 400;
        src_bursty = 1'b1;
        build_slot(INODE_MAGIC, 16'h81A4, 8'd2, FMT_EXTENTS, 32'd30, 64'h0);
        send_slot(64'h0000_0000_0003_4000, 200);
        drain(4);
        write_slot_size(12'd256);
        // illegal sizes must leave it in place
        foreach (bad_sizes[i])
            write_slot_size(bad_sizes[i]);
        finish_slot();
        sink_style = 1;

        // v3 with its own number, extents exactly filling the fork
        build_slot(INODE_MAGIC, 16'hFFFF, VERSION_V3, FMT_EXTENTS, 32'd5, '1);
        send_slot('1, sb.slot_size);
        sink_style = 2;
        // extents cut at slot end, extent bytes at zeros then ones
        build_slot(INODE_MAGIC, 16'hA1FF, 8'd2, FMT_EXTENTS, 32'd200, 64'h0);
        for (int i = 96; i < 112; i++)
            slot_img[i] = 8'h00;
        for (int i = 112; i < 256; i++)
            slot_img[i] = 8'hFF;
        send_slot(rand64(), sb.slot_size);
        sink_style = 0;
        random_slot();
        // v3 with zero embedded number falls back to the offset
        build_slot(INODE_MAGIC, 16'h1000, VERSION_V3, FMT_EXTENTS, 32'd65535, 64'h0);
        send_slot(64'h0000_0000_0010_0000, sb.slot_size);
        drain(4);

        // largest slot, cut once the counter is past the smaller end
        write_slot_size(12'd2048);
        sink_style = 1;
        build_slot(INODE_MAGIC, 16'h81A4, 8'd2, FMT_EXTENTS, 32'd200, 64'h0);
        send_slot(rand64(), 300);
        drain(4);
        write_slot_size(12'd256);
        finish_slot();
        drain(8);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_xfs_inode_slot_parser: done, clean");
        else
            $display("tb_xfs_inode_slot_parser: done, errors");
        $finish;
    end

endmodule
